// File: rtl/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

  localparam int CODE_W      = 4;
  localparam int SNR_W       = 16;
  localparam int HYST_W      = 15;
  localparam int COUNT_W     = 16;
  localparam int COUNT_N_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  // Entries that the threshold and code registers can hold.
  localparam int MAX_ENTRIES = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THR_LOW   = 3'd0,
    REG_THR_HIGH  = 3'd1,
    REG_CODES     = 3'd2,
    REG_ENTRIES   = 3'd3,
    REG_HYST      = 3'd4,
    REG_PERSIST   = 3'd5
  } sms_reg_e;

  typedef struct packed {
    logic [CODE_W-1:0]       current_constellation;
    logic signed [SNR_W-1:0] snr_estimate;
  } sms_sample_t;

  typedef struct packed {
    logic [CODE_W-1:0] chosen_constellation;
    logic              fallback_used;
  } sms_decision_t;

  typedef struct packed {
    logic [4*SNR_W-1:0]          threshold_low_group;
    logic [4*SNR_W-1:0]          threshold_high_group;
    logic [MAX_ENTRIES*CODE_W-1:0] entry_codes;
    logic [COUNT_N_W-1:0]        entries_in_use;
    logic [HYST_W-1:0]           hysteresis_margin;
    logic [COUNT_W-1:0]          persistence_limit;
  } sms_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  committed_code;
    logic               committed_valid;
    logic [CODE_W-1:0]  candidate_code;
    logic               candidate_valid;
    logic [COUNT_W-1:0] repeat_count;
  } sms_state_t;

endpackage

`default_nettype wire

// File: rtl/sms_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sms_sample_if;
  import sms_pkg::*;
  logic        valid;
  logic        ready;
  sms_sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sms_decision_if;
  import sms_pkg::*;
  logic          valid;
  logic          ready;
  sms_decision_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/snr_modulation_selector_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Modport  Payload                                       Role
// ---------  -------  --------------------------------------------  ----------------------
// sample     sink     current_constellation[3:0], snr_estimate[15:0]  SNR estimate per frame
// decision   source   chosen_constellation[3:0], fallback_used        committed constellation
// cfg_*      plain    cfg_index[2:0], cfg_data[63:0], cfg_write        register writes
//
// A sample is held in the sample register, then its decision in the result register,
// where a stalled decision waits; one transaction is taken every cycle while decision
// ready keeps the result stage moving. The rate is set by the state update loop: table
// lookup, threshold compare and persistence count are combinational between the sample
// register and the state/result registers. Synchronous active-high rst clears stage
// valids, selector state and config, but resets entries_in_use to one.
// A stalled decision holds both stages; ready drops only when both are full.

module snr_modulation_selector_unit #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  sms_sample_if.sink                            sample,
  sms_decision_if.source                        decision,
  input  wire logic                             cfg_write,
  input  wire logic [sms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sms_pkg::*;

  sms_cfg_t      cfg;
  sms_state_t    sel_state;
  sms_state_t    sel_state_next;
  sms_sample_t   s1_sample;
  logic          s1_valid;
  sms_decision_t out_decision;
  sms_decision_t decision_next;
  logic          out_valid;
  logic          advance;

  sms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Lookup and proposal logic between the sample stage and the result stage
  sms_decide #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_decide (
    .cfg        (cfg),
    .cur_state  (sel_state),
    .sample     (s1_sample),
    .state_next (sel_state_next),
    .decision   (decision_next)
  );

  // Result stage can move when empty or being drained this cycle
  assign advance      = !out_valid || decision.ready;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      sel_state <= '0;
    end else begin
      if (sample.ready) begin
        s1_valid <= sample.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      // State moves exactly once per item, as it leaves the sample stage
      if (advance && s1_valid) begin
        sel_state <= sel_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_sample <= sample.payload;
    end
    if (advance && s1_valid) begin
      out_decision <= decision_next;
    end
  end

  assign decision.valid   = out_valid;
  assign decision.payload = out_decision;

  // Reported code is always the code the selector carries forward
  a_commit_matches_out: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid) |=> (sel_state.committed_code == out_decision.chosen_constellation))
    else $error("committed code differs from reported decision");

  a_committed_sticky: assert property (@(posedge clk) disable iff (rst)
    sel_state.committed_valid |=> sel_state.committed_valid)
    else $error("committed_valid dropped");

  a_candidate_sticky: assert property (@(posedge clk) disable iff (rst)
    sel_state.candidate_valid |=> sel_state.candidate_valid)
    else $error("candidate_valid dropped");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !sel_state.candidate_valid |-> (sel_state.repeat_count == '0))
    else $error("repeat count running without a candidate");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_sample) && $stable(sel_state)))
    else $error("sample stage lost or state moved while stalled");

endmodule

`default_nettype wire

// File: rtl/sms_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sms_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sms_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sms_pkg::sms_cfg_t                     cfg
);
  import sms_pkg::*;

  sms_cfg_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.threshold_low_group  <= '0;
      cfg_q.threshold_high_group <= '0;
      cfg_q.entry_codes          <= '0;
      cfg_q.entries_in_use       <= COUNT_N_W'(1);
      cfg_q.hysteresis_margin    <= '0;
      cfg_q.persistence_limit    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THR_LOW:  cfg_q.threshold_low_group  <= cfg_data;
        REG_THR_HIGH: cfg_q.threshold_high_group <= cfg_data;
        REG_CODES:    cfg_q.entry_codes          <= cfg_data[MAX_ENTRIES*CODE_W-1:0];
        REG_ENTRIES:  cfg_q.entries_in_use       <= cfg_data[COUNT_N_W-1:0];
        REG_HYST:     cfg_q.hysteresis_margin    <= cfg_data[HYST_W-1:0];
        REG_PERSIST:  cfg_q.persistence_limit    <= cfg_data[COUNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/sms_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module sms_decide #(
  parameter int TABLE_DEPTH = 8
) (
  input  sms_pkg::sms_cfg_t      cfg,
  input  sms_pkg::sms_state_t    cur_state,
  input  sms_pkg::sms_sample_t   sample,
  output sms_pkg::sms_state_t    state_next,
  output sms_pkg::sms_decision_t decision
);
  import sms_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [COUNT_N_W-1:0] DEPTH_N = COUNT_N_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [2*4*SNR_W-1:0]    thr_flat;
  logic signed [SNR_W-1:0] thr  [TABLE_DEPTH];
  logic [CODE_W-1:0]       code [TABLE_DEPTH];
  logic [COUNT_N_W-1:0]    n_eff;
  logic [CODE_W-1:0]       eff_code;
  logic                    hit;
  logic [IDX_W-1:0]        found;
  logic [IDX_W-1:0]        up_idx;
  logic [IDX_W-1:0]        down_idx;
  logic                    up_ok;
  logic signed [SNR_W:0]   up_bound;
  logic                    go_down;
  logic                    go_up;
  logic                    propose_en;
  logic [CODE_W-1:0]       propose_code;
  logic [COUNT_W:0]        count_inc;

  assign thr_flat = {cfg.threshold_high_group, cfg.threshold_low_group};

  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      thr[k]  = thr_flat[SNR_W*k +: SNR_W];
      code[k] = cfg.entry_codes[CODE_W*k +: CODE_W];
    end
  end

  // Table size: zero acts as one, oversize clamps to the depth
  always_comb begin
    if (cfg.entries_in_use == '0) begin
      n_eff = COUNT_N_W'(1);
    end else if (cfg.entries_in_use > DEPTH_N) begin
      n_eff = DEPTH_N;
    end else begin
      n_eff = cfg.entries_in_use;
    end
  end

  // Unknown committed code takes the link's current code
  assign eff_code = cur_state.committed_valid ? cur_state.committed_code
                                              : sample.current_constellation;

  // Lowest matching entry wins
  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if ((COUNT_N_W'(k) < n_eff) && (code[k] == eff_code)) begin
        hit   = 1'b1;
        found = IDX_W'(k);
      end
    end
  end

  assign up_idx   = (found == LAST_IDX) ? found : found + IDX_W'(1);
  assign down_idx = (found == '0) ? found : found - IDX_W'(1);
  assign up_ok    = (COUNT_N_W'(found) + COUNT_N_W'(1)) < n_eff;
  assign up_bound = $signed({thr[up_idx][SNR_W-1], thr[up_idx]})
                  + $signed({2'b00, cfg.hysteresis_margin});

  assign go_down = (found != '0) && (sample.snr_estimate < thr[found]);
  assign go_up   = !go_down && up_ok &&
                   ($signed({sample.snr_estimate[SNR_W-1], sample.snr_estimate}) > up_bound);

  assign propose_en   = hit && (go_down || go_up);
  assign propose_code = go_down ? code[down_idx] : code[up_idx];
  assign count_inc    = {1'b0, cur_state.repeat_count} + (COUNT_W+1)'(1);

  always_comb begin
    state_next                 = cur_state;
    state_next.committed_code  = eff_code;
    state_next.committed_valid = 1'b1;
    if (!hit) begin
      state_next.committed_code = sample.current_constellation;
    end else if (propose_en) begin
      if (!cur_state.candidate_valid || (propose_code != cur_state.candidate_code)) begin
        state_next.candidate_code  = propose_code;
        state_next.candidate_valid = 1'b1;
        state_next.repeat_count    = '0;
      end else if (count_inc >= {1'b0, cfg.persistence_limit}) begin
        state_next.repeat_count   = '0;
        state_next.committed_code = cur_state.candidate_code;
      end else begin
        state_next.repeat_count = count_inc[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    decision.chosen_constellation = state_next.committed_code;
    decision.fallback_used        = !hit;
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sms_pkg::*;

  localparam int TABLE_DEPTH = 8;

  // Receiver behavior, re-drawn whenever its mode count runs out.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  // ---------------------------------------------------------------------------
  // Decision tracker: a cycle-free copy of the selector. It keeps its own
  // register image and selector state and queues the decision that each
  // accepted sample transaction must produce, in order.
  // ---------------------------------------------------------------------------
  class decision_tracker;
    logic [63:0] thr_low;
    logic [63:0] thr_high;
    logic [31:0] codes;
    logic [3:0]  n_entries;
    logic [14:0] margin;
    logic [15:0] limit;

    logic [3:0]  committed;
    bit          committed_known;
    logic [3:0]  candidate;
    bit          candidate_known;
    int          repeats;

    sms_decision_t due[$];
    int            mismatches;

    function new();
      thr_low         = '0;
      thr_high        = '0;
      codes           = '0;
      n_entries       = 4'd1;
      margin          = '0;
      limit           = '0;
      committed       = '0;
      committed_known = 1'b0;
      candidate       = '0;
      candidate_known = 1'b0;
      repeats         = 0;
      mismatches      = 0;
    endfunction

    function void write_reg(sms_reg_e r, logic [63:0] v);
      case (r)
        REG_THR_LOW:  thr_low   = v;
        REG_THR_HIGH: thr_high  = v;
        REG_CODES:    codes     = v[31:0];
        REG_ENTRIES:  n_entries = v[3:0];
        REG_HYST:     margin    = v[14:0];
        REG_PERSIST:  limit     = v[15:0];
        default: ;
      endcase
    endfunction

    // 0 acts as one entry, anything past the table acts as a full table
    function int entries_used();
      if (n_entries == 0) return 1;
      if (n_entries > TABLE_DEPTH) return TABLE_DEPTH;
      return n_entries;
    endfunction

    function int threshold(int k);
      logic signed [15:0] t;
      t = (k < 4) ? thr_low[16*k +: 16] : thr_high[16*(k-4) +: 16];
      return t;
    endfunction

    function logic [3:0] code_at(int k);
      return codes[4*k +: 4];
    endfunction

    function void propose(logic [3:0] code);
      int lim;
      lim = limit;
      if (!candidate_known || code != candidate) begin
        candidate       = code;
        candidate_known = 1'b1;
        repeats         = 0;
      end else begin
        repeats++;
        if (repeats >= lim) begin
          repeats         = 0;
          committed       = candidate;
          committed_known = 1'b1;
        end
      end
    endfunction

    function void note_sample(sms_sample_t s);
      int n;
      int found;
      int snr;
      int up_level;
      sms_decision_t d;
      n     = entries_used();
      snr   = s.snr_estimate;
      found = -1;
      if (!committed_known) begin
        committed       = s.current_constellation;
        committed_known = 1'b1;
      end
      for (int k = 0; k < n; k++)
        if (found < 0 && code_at(k) == committed) found = k;
      if (found < 0) begin
        // off-table: take the link's code, leave the candidate alone
        committed              = s.current_constellation;
        d.chosen_constellation = s.current_constellation;
        d.fallback_used        = 1'b1;
      end else begin
        up_level = margin;
        if (found + 1 < n) up_level += threshold(found + 1);
        if (found > 0 && snr < threshold(found))
          propose(code_at(found - 1));
        else if (found + 1 < n && snr > up_level)
          propose(code_at(found + 1));
        d.chosen_constellation = committed;
        d.fallback_used        = 1'b0;
      end
      due.push_back(d);
    endfunction

    function void check_decision(sms_decision_t got);
      sms_decision_t want;
      if (due.size() == 0) begin
        $display("%0t: decision with none due: chosen %0d fallback %0b",
                 $time, got.chosen_constellation, got.fallback_used);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (got.chosen_constellation !== want.chosen_constellation) begin
        $display("%0t: chosen_constellation expected %0d actual %0d",
                 $time, want.chosen_constellation, got.chosen_constellation);
        mismatches++;
      end
      if (got.fallback_used !== want.fallback_used) begin
        $display("%0t: fallback_used expected %0b actual %0b",
                 $time, want.fallback_used, got.fallback_used);
        mismatches++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, DUT and channels
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  sms_sample_if   sample_ch();
  sms_decision_if decision_ch();

  decision_tracker sb = new();

  // sender burst state and the slowly drifting SNR level
  int burst_left = 0;
  int snr_level  = 0;

  snr_modulation_selector_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .decision  (decision_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // All six registers back to back, one per edge; the tracker follows each
  // write at the edge that commits it.
  task automatic load_config(input sms_cfg_t c);
    sms_reg_e    order[6];
    logic [63:0] word;
    order = '{REG_THR_LOW, REG_THR_HIGH, REG_CODES, REG_ENTRIES, REG_HYST, REG_PERSIST};
    foreach (order[i]) begin
      case (order[i])
        REG_THR_LOW:  word = c.threshold_low_group;
        REG_THR_HIGH: word = c.threshold_high_group;
        REG_CODES:    word = 64'(c.entry_codes);
        REG_ENTRIES:  word = 64'(c.entries_in_use);
        REG_HYST:     word = 64'(c.hysteresis_margin);
        default:      word = 64'(c.persistence_limit);
      endcase
      cfg_write <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= word;
      @(posedge clk);
      sb.write_reg(order[i], word);
    end
    cfg_write <= 1'b0;
  endtask

  // Offer one sample; returns at the edge where it was taken. Bursts of
  // random length, mostly separated by random gaps with valid low.
  task automatic send_sample(input logic [3:0] cur, input logic [15:0] snr);
    int gap;
    sms_sample_t s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s.current_constellation = cur;
    s.snr_estimate          = snr;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= s;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(s);
  endtask

  // Every decision must be back before registers change; the extra cycles
  // cover the two-stage pipe.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly ordered tables with distinct codes so the selector can walk;
  // sometimes raw random words, duplicates, and out-of-range entry counts.
  function automatic sms_cfg_t random_plan();
    sms_cfg_t   c;
    int         t;
    int         k;
    logic [3:0] base;
    logic [3:0] stride;
    if ($urandom_range(0, 4) != 0) begin
      t = $urandom_range(0, 6000);
      t -= 5000;
      for (k = 0; k < MAX_ENTRIES; k++) begin
        if (k < 4) c.threshold_low_group[16*k +: 16] = 16'(clamp16(t));
        else       c.threshold_high_group[16*(k-4) +: 16] = 16'(clamp16(t));
        t += $urandom_range(50, 2500);
      end
    end else begin
      c.threshold_low_group  = {$urandom, $urandom};
      c.threshold_high_group = {$urandom, $urandom};
    end
    if ($urandom_range(0, 3) == 0) begin
      c.entry_codes = $urandom;
    end else begin
      base   = 4'($urandom);
      stride = 4'($urandom_range(0, 7) * 2 + 1);
      for (k = 0; k < MAX_ENTRIES; k++) c.entry_codes[4*k +: 4] = 4'(base + stride * k);
    end
    case ($urandom_range(0, 9))
      0:       c.entries_in_use = 4'd0;
      1:       c.entries_in_use = 4'($urandom_range(9, 15));
      2:       c.entries_in_use = 4'd1;
      default: c.entries_in_use = 4'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 7))
      0:       c.hysteresis_margin = 15'd0;
      1:       c.hysteresis_margin = 15'h7FFF;
      default: c.hysteresis_margin = 15'($urandom_range(0, 600));
    endcase
    case ($urandom_range(0, 9))
      0:       c.persistence_limit = 16'd0;
      1:       c.persistence_limit = 16'hFFFF;
      2:       c.persistence_limit = 16'($urandom);
      default: c.persistence_limit = 16'($urandom_range(0, 4));
    endcase
    return c;
  endfunction

  // Link code mostly from the live table; SNR mostly a random walk with
  // jumps onto entry thresholds, plus noise and rail values.
  function automatic sms_sample_t next_sample();
    sms_sample_t s;
    int n;
    int k;
    n = sb.entries_used();
    k = $urandom_range(0, n - 1);
    s.current_constellation = ($urandom_range(0, 3) == 0) ? 4'($urandom) : sb.code_at(k);
    case ($urandom_range(0, 19))
      0, 1: s.snr_estimate = 16'($urandom);
      2:    s.snr_estimate = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      3, 4: begin
        snr_level = clamp16(sb.threshold($urandom_range(0, n - 1))
                            + int'($urandom_range(0, 400)) - 200);
        s.snr_estimate = 16'(snr_level);
      end
      default: begin
        snr_level = clamp16(snr_level + int'($urandom_range(0, 200)) - 100);
        s.snr_estimate = 16'(snr_level);
      end
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Decision monitor: every accepted decision transaction is checked at the
  // edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && decision_ch.valid && decision_ch.ready)
      sb.check_decision(decision_ch.payload);
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between always-ready, coin-flip and mostly-stalled,
  // and now and then holds ready low for a long stretch so the pipe fills
  // and sample ready drops. The first long hold is forced.
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int cycle;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    cycle     = 0;
    decision_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (hold_left == 0 && (cycle == 300 || $urandom_range(0, 499) == 0))
        hold_left = $urandom_range(30, 90);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        decision_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: decision_ch.ready <= 1'b1;
          RX_COIN: decision_ch.ready <= 1'($urandom_range(0, 1));
          default: decision_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    sms_cfg_t c;
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset table: one entry, code 0. First transaction finds no committed
    // code and adopts the link's; rails on both fields.
    send_sample(4'd0, 16'h8000);
    send_sample(4'd15, 16'h7FFF);
    drain();

    // Entry 0 threshold at the top rail (bottom never steps down), code 3
    // twice (lowest match wins), entry count 12 (acts as 8), maximum
    // hysteresis so threshold plus margin would wrap if done at 16 bits.
    c = '{64'h03E8_0000_FC18_7FFF, 64'h8000_8000_8000_7FFF, 32'hFDB9_7331,
          4'd12, 15'h7FFF, 16'd0};
    load_config(c);
    send_sample(4'd5, 16'h0000);    // committed 0 is off-table
    send_sample(4'd3, 16'h0000);    // committed 5 is off-table, adopt 3
    send_sample(4'd3, 16'h8000);    // step down proposed
    send_sample(4'd3, 16'h8000);    // repeats, commits to bottom entry
    send_sample(4'd3, 16'h8000);    // bottom entry holds
    send_sample(4'd0, 16'h7FFF);    // step up proposed
    send_sample(4'd0, 16'h7FFF);    // commits
    send_sample(4'd0, 16'h7FFF);    // SNR equal to threshold plus margin: stays
    drain();

    // Entry count 0 acts as one entry, which is also the top entry.
    c.entries_in_use    = 4'd0;
    c.hysteresis_margin = 15'd0;
    c.persistence_limit = 16'hFFFF;
    load_config(c);
    send_sample(4'd9, 16'h0000);
    send_sample(4'd1, 16'h0005);
    send_sample(4'd1, 16'h8000);
    drain();

    // Persistence of two: climb, step onto the duplicate, then fall back.
    c.entries_in_use    = 4'd8;
    c.persistence_limit = 16'd2;
    load_config(c);
    send_sample(4'd1, 16'h7FFF);
    send_sample(4'd1, 16'h7FFF);
    send_sample(4'd1, 16'h7FFF);
    send_sample(4'd1, 16'h0001);
    repeat (3) send_sample(4'd3, 16'hEC78);
    drain();

    // Random phases, each with its own table and settings.
    repeat (8) begin
      load_config(random_plan());
      snr_level = int'($urandom_range(0, 8000)) - 5000;
      repeat (60) begin
        c.threshold_low_group = '0;
        begin
          sms_sample_t s;
          s = next_sample();
          send_sample(s.current_constellation, s.snr_estimate);
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
